// File: rtl/bpfa_pkg.sv
// Shared types and constants of the bitmap page frame allocator.
package bpfa_pkg;

	localparam int PAGE_W     = 16;
	localparam int END_W      = 17;
	localparam int OP_W       = 3;
	localparam int ST_W       = 2;
	localparam int WORD_BITS  = 64;
	localparam int BIT_W      = 6;
	localparam int MAX_SCAN_WORDS = 1024;
	localparam int S_DATA_W   = 40;
	localparam int M_DATA_W   = 24;
	localparam int M_FIELDS_W = PAGE_W + ST_W + 1;

	typedef enum logic [OP_W-1:0] {
		OP_ALLOC      = 3'd0,
		OP_FREE       = 3'd1,
		OP_QUERY      = 3'd2,
		OP_RANGE_FREE = 3'd3,
		OP_RANGE_USED = 3'd4
	} op_t;

	typedef enum logic [ST_W-1:0] {
		ST_OK      = 2'd0,
		ST_NO_FREE = 2'd1,
		ST_BOUNDS  = 2'd2
	} status_t;

	typedef enum logic [1:0] {
		S_CLEAR,
		S_IDLE,
		S_SWEEP,
		S_FINISH
	} state_t;

	typedef struct packed {
		logic clear;
		logic accept;
		logic sweep;
		logic load_out;
	} cmd_t;

	typedef struct packed {
		logic clear_done;
		logic need_sweep;
		logic sweep_done;
		logic out_free;
	} sts_t;

endpackage

// File: rtl/bpfa_ram.sv
// Generic single-write, single-read RAM with registered read data.
module bpfa_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 1024,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

// File: rtl/bpfa_ctrl.sv
// Controller state machine: clearing pass, accept, word sweep and result hand-off.
module bpfa_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           s_valid,
	output logic           s_ready,
	input  bpfa_pkg::sts_t sts,
	output bpfa_pkg::cmd_t cmd
);
	bpfa_pkg::state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= bpfa_pkg::S_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		s_ready = 1'b0;
		case (state_q)
			bpfa_pkg::S_CLEAR: begin
				cmd.clear = 1'b1;
				if (sts.clear_done) begin
					state_d = bpfa_pkg::S_IDLE;
				end
			end
			bpfa_pkg::S_IDLE: begin
				s_ready = 1'b1;
				if (s_valid) begin
					cmd.accept = 1'b1;
					state_d = sts.need_sweep ? bpfa_pkg::S_SWEEP : bpfa_pkg::S_FINISH;
				end
			end
			bpfa_pkg::S_SWEEP: begin
				cmd.sweep = 1'b1;
				if (sts.sweep_done) begin
					state_d = bpfa_pkg::S_FINISH;
				end
			end
			bpfa_pkg::S_FINISH: begin
				if (sts.out_free) begin
					cmd.load_out = 1'b1;
					state_d = bpfa_pkg::S_IDLE;
				end
			end
			default: begin
				state_d = bpfa_pkg::S_IDLE;
			end
		endcase
	end

endmodule

// File: rtl/bpfa_dp.sv
// Datapath: operation decode, map memory sweep with read-modify-write, output register.
module bpfa_dp #(
	parameter int NUM_PAGES = 65536
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  bpfa_pkg::cmd_t                    cmd,
	output bpfa_pkg::sts_t                    sts,
	input  logic [bpfa_pkg::OP_W-1:0]         s_axis_tuser,
	input  logic [bpfa_pkg::S_DATA_W-1:0]     s_axis_tdata,
	output logic                              m_axis_tvalid,
	input  logic                              m_axis_tready,
	output logic [bpfa_pkg::M_DATA_W-1:0]     m_axis_tdata
);
	localparam int WB        = bpfa_pkg::WORD_BITS;
	localparam int MAP_WORDS = (NUM_PAGES + WB - 1) / WB;
	localparam int WAW       = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
	localparam int SCAN_WORDS = (MAP_WORDS < bpfa_pkg::MAX_SCAN_WORDS) ?
		MAP_WORDS : bpfa_pkg::MAX_SCAN_WORDS;
	localparam int PW = bpfa_pkg::PAGE_W;
	localparam int EW = bpfa_pkg::END_W;
	localparam int BW = bpfa_pkg::BIT_W;

	// Input unpacking.
	logic [PW-1:0]    in_page;
	logic [EW-1:0]    in_end;
	logic [EW-1:0]    end_m1;
	bpfa_pkg::op_t    in_op;
	logic             page_oob;
	logic             range_bad;

	assign in_page   = s_axis_tdata[PW-1:0];
	assign in_end    = s_axis_tdata[PW+EW-1:PW];
	assign end_m1    = in_end - EW'(1);
	assign in_op     = bpfa_pkg::op_t'(s_axis_tuser);
	assign page_oob  = 32'(in_page) >= 32'(NUM_PAGES);
	assign range_bad = (32'(in_end) > 32'(NUM_PAGES)) || ({1'b0, in_page} > in_end);

	// Decode of the incoming word into a sweep description.
	logic               d_sweep;
	logic [WAW-1:0]     d_first, d_last;
	logic [BW-1:0]      d_lo, d_hi;
	bpfa_pkg::status_t  d_status;

	always_comb begin
		d_sweep  = 1'b0;
		d_first  = WAW'(in_page[PW-1:BW]);
		d_last   = WAW'(in_page[PW-1:BW]);
		d_lo     = in_page[BW-1:0];
		d_hi     = in_page[BW-1:0];
		d_status = bpfa_pkg::ST_OK;
		case (in_op)
			bpfa_pkg::OP_ALLOC: begin
				d_sweep  = 1'b1;
				d_first  = '0;
				d_last   = WAW'(SCAN_WORDS - 1);
				d_status = bpfa_pkg::ST_NO_FREE;
			end
			bpfa_pkg::OP_FREE, bpfa_pkg::OP_QUERY: begin
				if (page_oob) begin
					d_status = bpfa_pkg::ST_BOUNDS;
				end else begin
					d_sweep = 1'b1;
				end
			end
			bpfa_pkg::OP_RANGE_FREE, bpfa_pkg::OP_RANGE_USED: begin
				if (range_bad) begin
					d_status = bpfa_pkg::ST_BOUNDS;
				end else if ({1'b0, in_page} != in_end) begin
					d_sweep = 1'b1;
					d_last  = WAW'(end_m1[EW-1:BW]);
					d_hi    = end_m1[BW-1:0];
				end
			end
			default: begin
				d_sweep = 1'b0;
			end
		endcase
	end

	// Operation registers.
	bpfa_pkg::op_t     op_q;
	logic [WAW-1:0]    first_q, last_q;
	logic [BW-1:0]     lo_q, hi_q;
	bpfa_pkg::status_t res_status_q;
	logic [PW-1:0]     res_page_q;
	logic              res_free_q;

	// Sweep control.
	logic [WAW-1:0]    ptr_q;
	logic              issued_last_q;
	logic              issue;
	logic              rvalid_s1;
	logic [WAW-1:0]    raddr_s1;
	logic              last_s1;
	logic [WAW-1:0]    clr_q;

	// Memory ports.
	logic              ram_we;
	logic [WAW-1:0]    ram_waddr;
	logic [WB-1:0]     ram_wdata;
	logic [WB-1:0]     rd_data;

	assign issue = cmd.sweep && !issued_last_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			issued_last_q <= 1'b1;
			rvalid_s1     <= 1'b0;
			clr_q         <= '0;
		end else begin
			rvalid_s1 <= issue;
			if (cmd.clear) begin
				clr_q <= WAW'(clr_q + 1'b1);
			end
			if (cmd.accept) begin
				issued_last_q <= 1'b0;
			end else if (issue) begin
				issued_last_q <= (ptr_q == last_q);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			ptr_q <= d_first;
		end else if (issue) begin
			ptr_q <= WAW'(ptr_q + 1'b1);
		end
		raddr_s1 <= ptr_q;
		last_s1  <= (ptr_q == last_q);
	end

	// Processing of the word read in the previous cycle.
	logic [WB-1:0]  free_bits;
	logic [WB-1:0]  low_bit;
	logic [BW-1:0]  low_idx;
	logic [WB-1:0]  mask;
	logic [BW-1:0]  lo_eff, hi_eff;
	logic           sw_we;
	logic [WB-1:0]  sw_wdata;
	logic           sw_done;
	logic           alloc_hit;
	logic           query_done;

	assign free_bits = ~rd_data;
	assign low_bit   = free_bits & (~free_bits + WB'(1));
	assign lo_eff    = (raddr_s1 == first_q) ? lo_q : '0;
	assign hi_eff    = last_s1 ? hi_q : '1;

	always_comb begin
		low_idx = '0;
		for (int b = WB - 1; b >= 0; b--) begin
			if (free_bits[b]) begin
				low_idx = BW'(b);
			end
		end
	end

	always_comb begin
		for (int b = 0; b < WB; b++) begin
			mask[b] = (BW'(b) >= lo_eff) && (BW'(b) <= hi_eff);
		end
	end

	always_comb begin
		sw_we      = 1'b0;
		sw_wdata   = rd_data;
		sw_done    = 1'b0;
		alloc_hit  = 1'b0;
		query_done = 1'b0;
		if (cmd.sweep && rvalid_s1) begin
			case (op_q)
				bpfa_pkg::OP_ALLOC: begin
					if (free_bits != '0) begin
						alloc_hit = 1'b1;
						sw_we     = 1'b1;
						sw_wdata  = rd_data | low_bit;
						sw_done   = 1'b1;
					end else begin
						sw_done = last_s1;
					end
				end
				bpfa_pkg::OP_FREE, bpfa_pkg::OP_RANGE_FREE: begin
					sw_we    = 1'b1;
					sw_wdata = rd_data & ~mask;
					sw_done  = last_s1;
				end
				bpfa_pkg::OP_RANGE_USED: begin
					sw_we    = 1'b1;
					sw_wdata = rd_data | mask;
					sw_done  = last_s1;
				end
				bpfa_pkg::OP_QUERY: begin
					query_done = 1'b1;
					sw_done    = 1'b1;
				end
				default: begin
					sw_done = 1'b1;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			op_q         <= in_op;
			first_q      <= d_first;
			last_q       <= d_last;
			lo_q         <= d_lo;
			hi_q         <= d_hi;
			res_status_q <= d_status;
			res_page_q   <= '0;
			res_free_q   <= 1'b0;
		end else begin
			if (alloc_hit) begin
				res_status_q <= bpfa_pkg::ST_OK;
				res_page_q   <= PW'({raddr_s1, low_idx});
			end
			if (query_done) begin
				res_free_q <= ~rd_data[lo_q];
			end
		end
	end

	// The clearing pass and the sweep share the single write port.
	assign ram_we    = cmd.clear || sw_we;
	assign ram_waddr = cmd.clear ? clr_q : raddr_s1;
	assign ram_wdata = cmd.clear ? '1 : sw_wdata;

	bpfa_ram #(
		.WIDTH(WB),
		.DEPTH(MAP_WORDS)
	) u_map (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (issue),
		.raddr (ptr_q),
		.rdata (rd_data)
	);

	// Output register.
	logic                          m_valid_q;
	logic [bpfa_pkg::M_DATA_W-1:0] m_data_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if (cmd.load_out) begin
			m_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			m_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_out) begin
			m_data_q <= {{(bpfa_pkg::M_DATA_W - bpfa_pkg::M_FIELDS_W){1'b0}},
				res_free_q, res_status_q, res_page_q};
		end
	end

	assign m_axis_tvalid = m_valid_q;
	assign m_axis_tdata  = m_data_q;

	assign sts.clear_done = (clr_q == WAW'(MAP_WORDS - 1));
	assign sts.need_sweep = d_sweep;
	assign sts.sweep_done = sw_done;
	assign sts.out_free   = !m_valid_q || m_axis_tready;

endmodule

// File: rtl/bitmap_page_frame_allocator_top.sv
// Top level of the bitmap page frame allocator.
//
// One word in on the slave stream carries one operation (tuser: opcode; tdata: page
// number and exclusive range end). One word out on the master stream carries the
// result: granted page, status, and the free flag of a query.
// Each page frame has one bit in a map memory of 64-bit words (1 = used). An item
// walks the map words it touches through one read port and one write port, one word
// per cycle, with a read-modify-write overlapped across consecutive words.
// The words visited are 1 for free and query, the span of words for a range operation,
// and up to 1024 words (or the map size if smaller) for an allocate that scans from page
// zero and stops at the first word holding a free page. Bounds errors, empty ranges
// and unknown opcodes visit no map word.
// One item is processed at a time; the next item is taken the cycle after the previous
// result has moved into the output register, even if the receiver has not taken it.
// When the receiver stalls, the result waits in the output register and a finished
// item waits in the block, holding tready low until the register frees.
// After reset the map is filled with ones (every page used) by a pass of one word per
// cycle over all ceil(NUM_PAGES / 64) map words, during which tready stays low.
module bitmap_page_frame_allocator_top #(
	parameter int NUM_PAGES = 65536
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          s_axis_tvalid,
	output logic                          s_axis_tready,
	// [15:0] page_number, [32:16] range_end, [39:33] zero
	input  logic [bpfa_pkg::S_DATA_W-1:0] s_axis_tdata,
	// [2:0] opcode
	input  logic [bpfa_pkg::OP_W-1:0]     s_axis_tuser,
	output logic                          m_axis_tvalid,
	input  logic                          m_axis_tready,
	// [15:0] result_page, [17:16] status, [18] page_free, [23:19] zero
	output logic [bpfa_pkg::M_DATA_W-1:0] m_axis_tdata
);
	bpfa_pkg::cmd_t cmd;
	bpfa_pkg::sts_t sts;

	bpfa_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.s_valid (s_axis_tvalid),
		.s_ready (s_axis_tready),
		.sts     (sts),
		.cmd     (cmd)
	);

	bpfa_dp #(
		.NUM_PAGES(NUM_PAGES)
	) u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.sts           (sts),
		.s_axis_tuser  (s_axis_tuser),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata)
	);

	// No word may be taken while the map is still being filled or swept.
	a_no_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.clear || cmd.sweep) |-> !s_axis_tready)
		else $error("input accepted while map busy");

	// A result must never overwrite one the receiver has not taken.
	a_load_when_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load_out |-> (!m_axis_tvalid || m_axis_tready))
		else $error("output register overwritten");

	// Every delivered result carries a defined status code.
	a_status_code: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> (m_axis_tdata[17:16] != 2'd3))
		else $error("undefined status code");

	// A failed allocate or bounds error never reports a page or a free flag.
	a_err_fields: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && (m_axis_tdata[17:16] != bpfa_pkg::ST_OK)) |->
		(m_axis_tdata[15:0] == 16'd0 && !m_axis_tdata[18]))
		else $error("error result with nonzero fields");

endmodule

// File: verif/bitmap_page_frame_allocator_top_test.sv
// Self-checking testbench of the bitmap page frame allocator: directed and random operations.
module bitmap_page_frame_allocator_top_test;
	import bpfa_pkg::*;

	localparam int NUM_PAGES      = 65536;
	localparam int MAP_WORDS      = (NUM_PAGES + WORD_BITS - 1) / WORD_BITS;
	localparam int ALLOC_LIMIT    = (NUM_PAGES < 65536) ? NUM_PAGES : 65536;
	localparam int WINDOW_PAGES   = 2048;
	localparam int RAND_ITEMS     = 555;
	localparam int LONG_HOLD      = 300;
	localparam int DRAIN_CYCLES   = 1100;
	localparam int WATCHDOG_LIMIT = 6000;

	localparam logic [OP_W-1:0] OP_RSVD5 = 3'd5;
	localparam logic [OP_W-1:0] OP_RSVD6 = 3'd6;
	localparam logic [OP_W-1:0] OP_RSVD7 = 3'd7;

	typedef struct packed {
		logic [PAGE_W-1:0] page;
		logic [ST_W-1:0]   status;
		logic              page_free;
	} alloc_reply_t;

	typedef struct packed {
		logic [OP_W-1:0]   op;
		logic [PAGE_W-1:0] page;
		logic [END_W-1:0]  rend;
		logic              typed;
		alloc_reply_t      reply;
	} probe_row_t;

	localparam int DIR_ROWS = 27;
	localparam probe_row_t DIRECTED [DIR_ROWS] = '{
		'{OP_QUERY,      16'd0,     17'd0,      1'b1, '{16'd0,     ST_OK,      1'b0}},
		'{OP_QUERY,      16'hFFFF,  17'd0,      1'b1, '{16'd0,     ST_OK,      1'b0}},
		'{OP_ALLOC,      16'd0,     17'd0,      1'b1, '{16'd0,     ST_NO_FREE, 1'b0}},
		'{OP_RANGE_FREE, 16'd0,     17'd0,      1'b1, '{16'd0,     ST_OK,      1'b0}},
		'{OP_RANGE_FREE, 16'hFFFF,  17'h1FFFF,  1'b1, '{16'd0,     ST_BOUNDS,  1'b0}},
		'{OP_RANGE_USED, 16'd0,     17'd65537,  1'b1, '{16'd0,     ST_BOUNDS,  1'b0}},
		'{OP_RANGE_FREE, 16'd10,    17'd5,      1'b1, '{16'd0,     ST_BOUNDS,  1'b0}},
		'{OP_RANGE_FREE, 16'hFFFF,  17'hFFFF,   1'b1, '{16'd0,     ST_OK,      1'b0}},
		'{OP_RANGE_FREE, 16'd0,     17'd64,     1'b1, '{16'd0,     ST_OK,      1'b0}},
		'{OP_ALLOC,      16'd0,     17'd0,      1'b1, '{16'd0,     ST_OK,      1'b0}},
		'{OP_ALLOC,      16'd0,     17'd0,      1'b1, '{16'd1,     ST_OK,      1'b0}},
		'{OP_FREE,       16'd0,     17'd0,      1'b1, '{16'd0,     ST_OK,      1'b0}},
		'{OP_ALLOC,      16'd0,     17'd0,      1'b1, '{16'd0,     ST_OK,      1'b0}},
		'{OP_QUERY,      16'd0,     17'd0,      1'b1, '{16'd0,     ST_OK,      1'b0}},
		'{OP_QUERY,      16'd63,    17'd0,      1'b1, '{16'd0,     ST_OK,      1'b1}},
		'{OP_RANGE_FREE, 16'd65472, 17'd65536,  1'b1, '{16'd0,     ST_OK,      1'b0}},
		'{OP_QUERY,      16'hFFFF,  17'd0,      1'b1, '{16'd0,     ST_OK,      1'b1}},
		'{OP_RANGE_USED, 16'd0,     17'd65536,  1'b1, '{16'd0,     ST_OK,      1'b0}},
		'{OP_ALLOC,      16'd0,     17'd0,      1'b1, '{16'd0,     ST_NO_FREE, 1'b0}},
		'{OP_FREE,       16'hFFFF,  17'd0,      1'b1, '{16'd0,     ST_OK,      1'b0}},
		'{OP_ALLOC,      16'd0,     17'd0,      1'b1, '{16'hFFFF,  ST_OK,      1'b0}},
		'{OP_RANGE_FREE, 16'd100,   17'd300,    1'b0, '0},
		'{OP_ALLOC,      16'hFFFF,  17'h1FFFF,  1'b0, '0},
		'{OP_RSVD5,      16'hFFFF,  17'h1FFFF,  1'b1, '{16'd0,     ST_OK,      1'b0}},
		'{OP_RSVD6,      16'h5555,  17'h0AAAA,  1'b1, '{16'd0,     ST_OK,      1'b0}},
		'{OP_RSVD7,      16'hAAAA,  17'h15555,  1'b1, '{16'd0,     ST_OK,      1'b0}},
		'{OP_RANGE_USED, 16'd0,     17'd65536,  1'b1, '{16'd0,     ST_OK,      1'b0}}
	};

	logic                clk;
	logic                arst_n        = 1'b0;
	logic                s_axis_tvalid = 1'b0;
	logic                s_axis_tready;
	logic [S_DATA_W-1:0] s_axis_tdata  = '0;
	logic [OP_W-1:0]     s_axis_tuser  = '0;
	logic                m_axis_tvalid;
	logic                m_axis_tready = 1'b0;
	logic [M_DATA_W-1:0] m_axis_tdata;

	logic [WORD_BITS-1:0] frame_map [MAP_WORDS];
	alloc_reply_t         replies_due [$];
	int                   op_tally [8];
	int                   status_tally [4];
	int                   mismatches = 0;
	bit                   calm = 1'b0;
	bit                   hold_req = 1'b0;

	bitmap_page_frame_allocator_top #(
		.NUM_PAGES(NUM_PAGES)
	) uut (
		.clk          (clk),
		.arst_n       (arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata (s_axis_tdata),
		.s_axis_tuser (s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata (m_axis_tdata)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Mostly short gaps, now and then a long one; none during calm stretches.
	function automatic int pick_gap();
		int r;
		if (calm)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		if (r < 90)
			return $urandom_range(1, 3);
		if (r < 98)
			return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	function automatic logic [PAGE_W-1:0] pick_page();
		if ($urandom_range(0, 9) == 0)
			return PAGE_W'($urandom);
		return PAGE_W'($urandom_range(0, WINDOW_PAGES - 1));
	endfunction

	// Applies one operation to the local copy of the map and returns the reply it earns.
	function automatic alloc_reply_t apply_to_frame_map(logic [OP_W-1:0] op,
			logic [PAGE_W-1:0] pg, logic [END_W-1:0] re);
		alloc_reply_t reply;
		int w, b, p;
		bit found;
		reply = '0;
		found = 1'b0;
		p = 0;
		case (op)
			OP_ALLOC: begin
				for (w = 0; w < MAP_WORDS && !found; w++) begin
					if (frame_map[w] != '1) begin
						for (b = 0; b < WORD_BITS && !found; b++) begin
							if (!frame_map[w][b]) begin
								found = 1'b1;
								p = w * WORD_BITS + b;
							end
						end
					end
				end
				if (found && p < ALLOC_LIMIT) begin
					frame_map[p >> BIT_W][p & (WORD_BITS - 1)] = 1'b1;
					reply.page = PAGE_W'(p);
				end else begin
					reply.status = ST_NO_FREE;
				end
			end
			OP_FREE: begin
				if (int'(pg) >= NUM_PAGES)
					reply.status = ST_BOUNDS;
				else
					frame_map[pg >> BIT_W][pg & (WORD_BITS - 1)] = 1'b0;
			end
			OP_QUERY: begin
				if (int'(pg) >= NUM_PAGES)
					reply.status = ST_BOUNDS;
				else
					reply.page_free = ~frame_map[pg >> BIT_W][pg & (WORD_BITS - 1)];
			end
			OP_RANGE_FREE, OP_RANGE_USED: begin
				if (int'(re) > NUM_PAGES || pg > re) begin
					reply.status = ST_BOUNDS;
				end else begin
					for (p = int'(pg); p < int'(re); p++)
						frame_map[p >> BIT_W][p & (WORD_BITS - 1)] = (op == OP_RANGE_USED);
				end
			end
			default: begin
			end
		endcase
		return reply;
	endfunction

	// Offers one operation word and records its reply once the block takes it.
	task automatic issue_op(input logic [OP_W-1:0] op, input logic [PAGE_W-1:0] pg,
			input logic [END_W-1:0] re, input logic typed, input alloc_reply_t typed_reply);
		int gap;
		alloc_reply_t predicted;
		gap = pick_gap();
		if (gap > 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= {{(S_DATA_W - PAGE_W - END_W){1'b0}}, re, pg};
		s_axis_tuser  <= op;
		@(posedge clk);
		while (!s_axis_tready)
			@(posedge clk);
		predicted = apply_to_frame_map(op, pg, re);
		replies_due.push_back(typed ? typed_reply : predicted);
		op_tally[op]++;
		status_tally[predicted.status]++;
	endtask

	initial begin : op_source
		int n, r;
		logic [OP_W-1:0]   op;
		logic [PAGE_W-1:0] pg;
		logic [END_W-1:0]  re;
		foreach (frame_map[i])
			frame_map[i] = '1;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;

		for (n = 0; n < DIR_ROWS; n++)
			issue_op(DIRECTED[n].op, DIRECTED[n].page, DIRECTED[n].rend,
				DIRECTED[n].typed, DIRECTED[n].reply);

		for (n = 0; n < RAND_ITEMS; n++) begin
			calm = ((n / 40) % 4 == 3);
			// The long receiver hold-off starts with a calm stretch so the input backs up.
			if (n == 120)
				hold_req = 1'b1;
			r = $urandom_range(0, 99);
			pg = PAGE_W'($urandom);
			re = END_W'($urandom);
			if (r < 30) begin
				op = OP_ALLOC;
			end else if (r < 48) begin
				op = OP_FREE;
				pg = pick_page();
			end else if (r < 66) begin
				op = OP_QUERY;
				pg = pick_page();
			end else if (r < 94) begin
				op = (r < 80) ? OP_RANGE_FREE : OP_RANGE_USED;
				r = $urandom_range(0, 99);
				if (r < 75) begin
					pg = PAGE_W'($urandom_range(0, WINDOW_PAGES - 1));
					re = END_W'(int'(pg) + $urandom_range(0, 160));
				end else if (r < 85) begin
					re = END_W'(int'(pg) + $urandom_range(0, NUM_PAGES - int'(pg)));
				end else if (r >= 93) begin
					// Start beyond the end.
					pg = PAGE_W'($urandom_range(1, 65535));
					re = END_W'(int'(pg) - $urandom_range(1, int'(pg)));
				end
			end else begin
				op = OP_W'($urandom_range(OP_RSVD5, OP_RSVD7));
			end
			issue_op(op, pg, re, 1'b0, '0);
		end
		s_axis_tvalid <= 1'b0;
		calm = 1'b0;

		while (replies_due.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("Ran %0d operations: %0d allocate, %0d free, %0d query, %0d range free, %0d range used, %0d unknown.",
			DIR_ROWS + RAND_ITEMS, op_tally[OP_ALLOC], op_tally[OP_FREE], op_tally[OP_QUERY],
			op_tally[OP_RANGE_FREE], op_tally[OP_RANGE_USED],
			op_tally[OP_RSVD5] + op_tally[OP_RSVD6] + op_tally[OP_RSVD7]);
		$display("Replies: %0d ok, %0d no free page, %0d out of bounds, with random stalls and one long output hold-off.",
			status_tally[ST_OK], status_tally[ST_NO_FREE], status_tally[ST_BOUNDS]);
		if (mismatches == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

	initial begin : result_sink
		int idle_left;
		alloc_reply_t due;
		idle_left = 0;
		forever begin
			@(posedge clk);
			if (m_axis_tvalid && m_axis_tready) begin
				if (replies_due.size() == 0) begin
					$error("result word with no operation pending: tdata %h", m_axis_tdata);
					mismatches++;
				end else begin
					due = replies_due.pop_front();
					if (m_axis_tdata[15:0] !== due.page) begin
						$error("result_page: expected %0d, got %0d", due.page, m_axis_tdata[15:0]);
						mismatches++;
					end
					if (m_axis_tdata[17:16] !== due.status) begin
						$error("status: expected %0d, got %0d", due.status, m_axis_tdata[17:16]);
						mismatches++;
					end
					if (m_axis_tdata[18] !== due.page_free) begin
						$error("page_free: expected %0d, got %0d", due.page_free, m_axis_tdata[18]);
						mismatches++;
					end
				end
			end
			if (hold_req) begin
				hold_req = 1'b0;
				idle_left = LONG_HOLD;
			end
			if (idle_left > 0) begin
				idle_left--;
				m_axis_tready <= 1'b0;
			end else begin
				m_axis_tready <= 1'b1;
				if (!calm && $urandom_range(0, 3) == 0)
					idle_left = pick_gap();
			end
		end
	end

	// Ends the run when no word has moved on either side for too long.
	initial begin : watchdog
		int quiet;
		quiet = 0;
		while (quiet < WATCHDOG_LIMIT) begin
			@(posedge clk);
			if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
				quiet = 0;
			else
				quiet++;
		end
		$error("no word moved for %0d cycles, %0d replies outstanding",
			WATCHDOG_LIMIT, replies_due.size());
		$display("== FAIL ==");
		$finish;
	end

endmodule

// File: filelist.f
rtl/bpfa_pkg.sv
rtl/bpfa_ram.sv
rtl/bpfa_ctrl.sv
rtl/bpfa_dp.sv
rtl/bitmap_page_frame_allocator_top.sv
verif/bitmap_page_frame_allocator_top_test.sv
